// File: rtl/tseq_pkg.sv
// Shared constants, payload structs and control structs of the event queue.
package tseq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] FUNC_INSERT    = 2'd0;
    localparam logic [1:0] FUNC_APPEND    = 2'd1;
    localparam logic [1:0] FUNC_POP_FRONT = 2'd2;
    localparam logic [1:0] FUNC_POP_BACK  = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [6:0]  entry_type;
        logic [31:0] entry_time;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  out_type;
        logic [31:0] out_time;
        logic [4:0]  occupancy;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic compare;
        logic apply;
    } tseq_cmd_t;

    typedef struct packed {
        logic rsp_pending;
    } tseq_stat_t;

endpackage

// File: rtl/timestamp_sorted_event_queue_unit.sv
// Top level of the timestamp sorted event queue: controller plus datapath.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  req     | in        | req_valid / req_stall | func, entry_type, entry_time
//  rsp     | out       | rsp_valid / rsp_stall | status, out_type, out_time, occupancy
//
// Each operation runs in three steps: capture, a parallel compare of all slots
// against the new timestamp, and the slot update that loads the result register.
// A new request transfer is taken only once the previous operation has done its update step.
// A result held by rsp_stall blocks only the update step of the following operation.
// Reset empties the queue at once; slot contents are not cleared.
module timestamp_sorted_event_queue_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  tseq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output tseq_pkg::rsp_t rsp
);

    tseq_pkg::tseq_cmd_t  cmd;
    tseq_pkg::tseq_stat_t stat;

    tseq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    tseq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// File: rtl/tseq_ctrl.sv
// Controller state machine that sequences capture, compare and update of one operation.
module tseq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic                rsp_stall,
    input  tseq_pkg::tseq_stat_t stat,
    output tseq_pkg::tseq_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_COMPARE = 3'b010,
        S_APPLY   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   can_apply;

    // The result register must be free, or emptied in this very cycle.
    assign can_apply = !(stat.rsp_pending && rsp_stall);
    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.compare = 1'b0;
        cmd.apply   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = S_APPLY;
            end
            S_APPLY:
            begin
                if (can_apply)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/tseq_datapath.sv
// Datapath of the event queue: slot row, parallel compare, count and result register.
module tseq_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tseq_pkg::req_t       req,
    input  logic                 rsp_stall,
    input  tseq_pkg::tseq_cmd_t  cmd,
    output tseq_pkg::tseq_stat_t stat,
    output logic                 rsp_valid,
    output tseq_pkg::rsp_t       rsp
);

    localparam int D = tseq_pkg::QUEUE_DEPTH;

    tseq_pkg::req_t                    item_reg;
    logic [D-1:0]                      gt_reg;
    logic [6:0]                        slot_type_reg [D];
    logic [tseq_pkg::TIME_BITS-1:0]    slot_time_reg [D];
    logic [tseq_pkg::CNT_W-1:0]        count_reg;
    logic [tseq_pkg::CNT_W-1:0]        count_next;
    logic                              rsp_valid_reg;
    tseq_pkg::rsp_t                    rsp_reg;
    tseq_pkg::rsp_t                    rsp_next;

    logic [6:0]                        prev_type [D];
    logic [tseq_pkg::TIME_BITS-1:0]    prev_time [D];
    logic [6:0]                        succ_type [D];
    logic [tseq_pkg::TIME_BITS-1:0]    succ_time [D];
    logic [D-1:0]                      after;
    logic [D-1:0]                      after_prev;
    logic [D-1:0]                      place;
    logic                              any_gt;
    logic                              is_put;
    logic                              is_pop;
    logic                              is_full;
    logic                              is_empty;
    logic                              put_ok;
    logic                              pop_ok;
    logic [tseq_pkg::IDX_W-1:0]        back_idx;
    logic [tseq_pkg::TIME_BITS-1:0]    new_time;

    assign new_time = tseq_pkg::TIME_BITS'(item_reg.entry_time);

    // Neighbour taps of each slot for the shift towards the back and the front.
    genvar g;
    generate
        for (g = 0; g < D; g++)
        begin : g_tap
            if (g == 0)
            begin : g_first
                assign prev_type[g]  = '0;
                assign prev_time[g]  = '0;
                assign after_prev[g] = 1'b0;
            end
            else
            begin : g_rest
                assign prev_type[g]  = slot_type_reg[g-1];
                assign prev_time[g]  = slot_time_reg[g-1];
                assign after_prev[g] = after[g-1];
            end
            if (g == D - 1)
            begin : g_last
                assign succ_type[g] = '0;
                assign succ_time[g] = '0;
            end
            else
            begin : g_inner
                assign succ_type[g] = slot_type_reg[g+1];
                assign succ_time[g] = slot_time_reg[g+1];
            end
            // A slot lies at or after the insert point when any slot up to it compares larger.
            assign after[g] = |(gt_reg & ({D{1'b1}} >> (D - 1 - g)));
            assign place[g] = gt_reg[g] ||
                              (!any_gt && (tseq_pkg::CNT_W'(g) == count_reg));
        end
    endgenerate

    assign any_gt   = after[D-1];
    assign is_put   = (item_reg.func == tseq_pkg::FUNC_INSERT) ||
                      (item_reg.func == tseq_pkg::FUNC_APPEND);
    assign is_pop   = !is_put;
    assign is_full  = (count_reg == tseq_pkg::CNT_W'(D));
    assign is_empty = (count_reg == '0);
    assign put_ok   = is_put && !is_full;
    assign pop_ok   = is_pop && !is_empty;
    assign back_idx = tseq_pkg::IDX_W'(count_reg - tseq_pkg::CNT_W'(1));

    always_comb
    begin
        count_next = count_reg;
        if (put_ok)
        begin
            count_next = count_reg + tseq_pkg::CNT_W'(1);
        end
        else if (pop_ok)
        begin
            count_next = count_reg - tseq_pkg::CNT_W'(1);
        end

        rsp_next.status   = tseq_pkg::ST_DONE;
        rsp_next.out_type = '0;
        rsp_next.out_time = '0;
        if (is_put && is_full)
        begin
            rsp_next.status = tseq_pkg::ST_FULL;
        end
        else if (is_pop && is_empty)
        begin
            rsp_next.status = tseq_pkg::ST_EMPTY;
        end
        else if (pop_ok && (item_reg.func == tseq_pkg::FUNC_POP_FRONT))
        begin
            rsp_next.out_type = slot_type_reg[0];
            rsp_next.out_time = 32'(slot_time_reg[0]);
        end
        else if (pop_ok)
        begin
            rsp_next.out_type = slot_type_reg[back_idx];
            rsp_next.out_time = 32'(slot_time_reg[back_idx]);
        end
        rsp_next.occupancy = 5'(count_next);
    end

    // Item capture, the parallel compare of every held slot with the new timestamp on an insert, and the result load.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req;
        end
        if (cmd.compare)
        begin
            for (int i = 0; i < D; i++)
            begin
                gt_reg[i] <= (item_reg.func == tseq_pkg::FUNC_INSERT) &&
                             (tseq_pkg::CNT_W'(i) < count_reg) &&
                             (new_time < slot_time_reg[i]);
            end
        end
        if (cmd.apply)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Slot row: each slot keeps, takes the new entry, or takes a neighbour.
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            for (int i = 0; i < D; i++)
            begin
                if (put_ok)
                begin
                    if (after_prev[i])
                    begin
                        slot_type_reg[i] <= prev_type[i];
                        slot_time_reg[i] <= prev_time[i];
                    end
                    else if (place[i])
                    begin
                        slot_type_reg[i] <= item_reg.entry_type;
                        slot_time_reg[i] <= new_time;
                    end
                end
                else if (pop_ok && (item_reg.func == tseq_pkg::FUNC_POP_FRONT))
                begin
                    slot_type_reg[i] <= succ_type[i];
                    slot_time_reg[i] <= succ_time[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.apply)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.rsp_pending = rsp_valid_reg;
    assign rsp_valid        = rsp_valid_reg;
    assign rsp              = rsp_reg;

endmodule

// File: rtl/tseq_checker.sv
// Port-level assertions for the event queue and their bind to the top level.
module tseq_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input tseq_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input tseq_pkg::rsp_t rsp
);

    // A stalled result must stay put until its transfer.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // Only one operation is in flight, so a request transfer closes the request side.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while an operation is in flight");

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.occupancy <= 5'(tseq_pkg::QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == tseq_pkg::ST_FULL |->
            rsp.occupancy == 5'(tseq_pkg::QUEUE_DEPTH) &&
            rsp.out_type == '0 && rsp.out_time == '0)
        else $error("full status with a queue that is not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == tseq_pkg::ST_EMPTY |->
            rsp.occupancy == '0 && rsp.out_type == '0 && rsp.out_time == '0)
        else $error("empty status with a queue that is not empty");

endmodule

bind timestamp_sorted_event_queue_unit tseq_checker u_tseq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
